// ===== rtl/core/sacl_pkg.sv =====
`timescale 1ns / 1ps
package sacl_pkg;

	localparam int TAG_W      = 32;
	localparam int CNT_W      = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OFFSET_BITS = 2'd0,
		CFG_INDEX_BITS  = 2'd1,
		CFG_WAYS_IN_USE = 2'd2
	} cfg_reg_t;

	localparam logic [4:0] OFFSET_BITS_RST = 5'd4;
	localparam logic [3:0] INDEX_BITS_RST  = 4'd8;
	localparam logic [2:0] WAYS_IN_USE_RST = 3'd4;

	// set address width, at least one bit
	function automatic int set_w(input int sib);
		return (sib > 0) ? sib : 1;
	endfunction

	// way position width, at least one bit
	function automatic int way_w(input int ways);
		return (ways > 1) ? $clog2(ways) : 1;
	endfunction

	// queued access word: {set, tag, last way position}
	function automatic int ent_w(input int sib, input int ways);
		return set_w(sib) + TAG_W + way_w(ways);
	endfunction

endpackage

// ===== rtl/core/set_assoc_cache_lru_hit_check.sv =====
`timescale 1ns / 1ps
// set-associative cache hit checker with least-recently-used replacement.
// each address word pushed in is split into offset, set index and tag using
// the configured field widths; the tag is looked up among the ways in use of
// its set, kept in recency order, and the set is reordered or refilled.
// one result word (hit flag and saturating running hit count) comes out per
// address, in order. a front end classifies addresses into a two-entry queue;
// a back end does a read-modify-write of one set row in the tag memory (row
// read, then write-back) and takes no new access until the write-back is
// done. results sit in a two-entry output queue, so the input keeps flowing
// while a result waits to be popped. after reset the back end clears the tag
// memory one set per cycle; full stays high meanwhile, but configuration
// writes are taken. configuration registers: index 0 offset bits, 1 index
// bits, 2 ways in use; write them only while the block is idle.
module set_assoc_cache_lru_hit_check #(
	parameter int SET_INDEX_BITS = 8,
	parameter int WAYS           = 4,
	parameter int ADDR_BITS      = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [sacl_pkg::TAG_W-1:0]      address,
	output logic                            empty,
	input  logic                            pop,
	output logic                            hit,
	output logic [sacl_pkg::CNT_W-1:0]      hit_count,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [sacl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sacl_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sacl_pkg::*;

	localparam int ENT_W = ent_w(SET_INDEX_BITS, WAYS);
	localparam int RES_W = CNT_W + 1;

	// front end to access queue
	logic [ENT_W-1:0] f_entry;
	logic             i_full;
	logic             i_empty;
	logic             i_pop;
	logic [ENT_W-1:0] i_head;

	// back end to result queue
	logic             b_push;
	logic [RES_W-1:0] b_word;
	logic             b_clearing;
	logic             o_full;
	logic [RES_W-1:0] o_head;

	sacl_front #(
		.SET_INDEX_BITS (SET_INDEX_BITS),
		.WAYS           (WAYS),
		.ADDR_BITS      (ADDR_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.address   (address),
		.entry     (f_entry)
	);

	// no address taken while the tag memory is being cleared
	assign full = i_full || b_clearing;

	sacl_queue #(
		.W     (ENT_W),
		.DEPTH (2)
	) u_acc_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push && !full),
		.wdata  (f_entry),
		.full   (i_full),
		.pop    (i_pop),
		.rdata  (i_head),
		.empty  (i_empty)
	);

	sacl_back #(
		.SET_INDEX_BITS (SET_INDEX_BITS),
		.WAYS           (WAYS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_empty (i_empty),
		.in_entry (i_head),
		.in_pop   (i_pop),
		.out_full (o_full),
		.out_push (b_push),
		.out_word (b_word),
		.clearing (b_clearing)
	);

	sacl_queue #(
		.W     (RES_W),
		.DEPTH (2)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (b_push),
		.wdata  (b_word),
		.full   (o_full),
		.pop    (pop),
		.rdata  (o_head),
		.empty  (empty)
	);

	// result word: hit flag above the count
	assign hit       = o_head[CNT_W];
	assign hit_count = o_head[CNT_W-1:0];

	// back end only writes a result when the result queue has room
	a_res_room: assert property (@(posedge clk) disable iff (!arst_n)
		b_push |-> !o_full)
		else $error("result word written into a full result queue");

	// nothing reaches the access queue while the tag memory is cleared
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		b_clearing |-> i_empty)
		else $error("access queued during tag memory clear");

	// a hit always comes with a non-zero running count
	a_hit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && hit) |-> (hit_count != '0))
		else $error("hit reported with zero hit count");

endmodule

// ===== rtl/core/sacl_queue.sv =====
`timescale 1ns / 1ps
module sacl_queue #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);
	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  store_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          wr_en;
	logic          rd_en;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign wr_en = push && !full;
	assign rd_en = pop && !empty;
	assign rdata = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + CW'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ===== rtl/core/sacl_front.sv =====
`timescale 1ns / 1ps
module sacl_front #(
	parameter int SET_INDEX_BITS = 8,
	parameter int WAYS           = 4,
	parameter int ADDR_BITS      = 32
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           cfg_valid,
	output logic                                           cfg_ready,
	input  logic [sacl_pkg::CFG_IDX_W-1:0]                 cfg_index,
	input  logic [sacl_pkg::CFG_DATA_W-1:0]                cfg_data,
	input  logic [sacl_pkg::TAG_W-1:0]                     address,
	output logic [sacl_pkg::ent_w(SET_INDEX_BITS, WAYS)-1:0] entry
);
	import sacl_pkg::*;

	localparam int SET_W = set_w(SET_INDEX_BITS);
	localparam int WIW   = way_w(WAYS);
	localparam int AW    = (ADDR_BITS < TAG_W) ? ADDR_BITS : TAG_W;
	localparam logic [TAG_W-1:0] AMASK = {TAG_W{1'b1}} >> (TAG_W - AW);

	logic [4:0]       offset_q;
	logic [3:0]       index_q;
	logic [2:0]       ways_q;
	logic [TAG_W-1:0] addr_m;
	logic [TAG_W-1:0] addr_sh;
	logic [3:0]       ib;
	logic [5:0]       tag_sh;
	logic [SET_W-1:0] set_idx;
	logic [TAG_W-1:0] tag;
	logic [WIW-1:0]   klast;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= OFFSET_BITS_RST;
			index_q  <= INDEX_BITS_RST;
			ways_q   <= WAYS_IN_USE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_OFFSET_BITS: offset_q <= cfg_data[4:0];
				CFG_INDEX_BITS:  index_q  <= cfg_data[3:0];
				CFG_WAYS_IN_USE: ways_q   <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// split the address into set and tag, and pick the last way position in use
	always_comb begin
		addr_m  = address & AMASK;
		ib      = (index_q > 4'(SET_INDEX_BITS)) ? 4'(SET_INDEX_BITS) : index_q;
		addr_sh = addr_m >> offset_q;
		set_idx = addr_sh[SET_W-1:0] & ~({SET_W{1'b1}} << ib);
		tag_sh  = {1'b0, offset_q} + {2'b00, ib};
		tag     = addr_m >> tag_sh;
		if (ways_q == 3'd0) begin
			klast = '0;
		end else if ({2'b00, ways_q} > 5'(WAYS)) begin
			klast = WIW'(WAYS - 1);
		end else begin
			klast = WIW'(ways_q - 3'd1);
		end
	end

	assign entry = {set_idx, tag, klast};

endmodule

// ===== rtl/core/sacl_back.sv =====
`timescale 1ns / 1ps
module sacl_back #(
	parameter int SET_INDEX_BITS = 8,
	parameter int WAYS           = 4
) (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  logic                                             in_empty,
	input  logic [sacl_pkg::ent_w(SET_INDEX_BITS, WAYS)-1:0] in_entry,
	output logic                                             in_pop,
	input  logic                                             out_full,
	output logic                                             out_push,
	output logic [sacl_pkg::CNT_W:0]                         out_word,
	output logic                                             clearing
);
	import sacl_pkg::*;

	localparam int SET_W = set_w(SET_INDEX_BITS);
	localparam int WIW   = way_w(WAYS);
	localparam int ROWS  = 1 << SET_INDEX_BITS;
	localparam int ROW_W = WAYS * (TAG_W + 1);

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_UPD   = 3'b100
	} state_t;

	state_t           state_q;
	logic [SET_W-1:0] clr_q;
	logic [SET_W-1:0] set_q;
	logic [TAG_W-1:0] tag_q;
	logic [WIW-1:0]   klast_q;
	logic [CNT_W-1:0] cnt_q;
	logic [ROW_W-1:0] rdata_q;
	logic [ROW_W-1:0] mem [ROWS];

	logic [SET_W-1:0] e_set;
	logic [TAG_W-1:0] e_tag;
	logic [WIW-1:0]   e_klast;
	logic             mem_we;
	logic [SET_W-1:0] waddr;
	logic [ROW_W-1:0] wdata;
	logic [ROW_W-1:0] new_row;
	logic             found;
	logic [CNT_W-1:0] cnt_next;

	logic [WAYS-1:0]  v;
	logic [WAYS-1:0]  nv;
	logic [TAG_W-1:0] t  [WAYS];
	logic [TAG_W-1:0] nt [WAYS];
	logic [WAYS-1:0]  le;
	logic [WAYS-1:0]  lt;
	logic [WAYS-1:0]  match;
	logic [WAYS-1:0]  first_m;
	logic [WAYS-1:0]  above;
	logic [WAYS-1:0]  shift;
	logic [WAYS-1:0]  inv;
	logic [WAYS-1:0]  first_inv;
	logic             last_valid;

	assign {e_set, e_tag, e_klast} = in_entry;

	assign clearing = (state_q == ST_CLEAR);
	assign in_pop   = (state_q == ST_IDLE) && !in_empty && !out_full;
	assign out_push = (state_q == ST_UPD);
	assign out_word = {found, cnt_next};
	assign mem_we   = clearing || out_push;
	assign waddr    = clearing ? clr_q : set_q;
	assign wdata    = clearing ? '0 : new_row;

	// tag memory: one row per set, valid bits low, tags above
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		if (in_pop) begin
			rdata_q <= mem[e_set];
		end
	end

	always_ff @(posedge clk) begin
		if (in_pop) begin
			set_q   <= e_set;
			tag_q   <= e_tag;
			klast_q <= e_klast;
		end
	end

	// lookup and recency reorder of one row
	always_comb begin
		v = rdata_q[WAYS-1:0];
		for (int i = 0; i < WAYS; i++) begin
			t[i]     = rdata_q[WAYS + i*TAG_W +: TAG_W];
			le[i]    = (WIW'(i) <= klast_q);
			lt[i]    = (WIW'(i) < klast_q);
			match[i] = v[i] && (t[i] == tag_q) && le[i];
		end
		found      = |match;
		first_m    = match & (~match + WAYS'(1));
		above      = ~(first_m - WAYS'(1));
		last_valid = v[klast_q];
		shift      = lt & (found ? above : {WAYS{last_valid}});
		nv = v;
		for (int i = 0; i < WAYS; i++) begin
			nt[i] = t[i];
		end
		for (int j = 0; j < WAYS - 1; j++) begin
			if (shift[j]) begin
				nv[j] = v[j+1];
				nt[j] = t[j+1];
			end
		end
		inv       = ~nv & le;
		first_inv = inv & (~inv + WAYS'(1));
		if (last_valid) begin
			nv[klast_q] = 1'b1;
			nt[klast_q] = tag_q;
		end else begin
			for (int j = 0; j < WAYS; j++) begin
				if (first_inv[j]) begin
					nv[j] = 1'b1;
					nt[j] = tag_q;
				end
			end
		end
		new_row[WAYS-1:0] = nv;
		for (int i = 0; i < WAYS; i++) begin
			new_row[WAYS + i*TAG_W +: TAG_W] = nt[i];
		end
		cnt_next = (found && (cnt_q != '1)) ? cnt_q + CNT_W'(1) : cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (clr_q == SET_W'(ROWS - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						clr_q <= clr_q + SET_W'(1);
					end
				end
				ST_IDLE: begin
					if (in_pop) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					cnt_q   <= cnt_next;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

endmodule
